/* src/bzf_pkg.sv */
// ----------------------------------------------------------------------------
// bzf_pkg - shared types and constants for the cubic Bezier flattener
// Curve and segment beat layouts, fixed-point widths and the command and
// status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bzf_pkg;

  // Coordinate format: signed, 8 fraction bits
  localparam int COORD_W = 24;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

  // Curve parameter and weights, unsigned Q1.16
  localparam int Q_W = 17;
  localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;
  // Weights carry a factor of three on the inner terms
  localparam int W_W = Q_W + 2;
  // Weight (made signed) times coordinate
  localparam int PROD_W = W_W + 1 + COORD_W;
  // Pair sums and the final four-term sum
  localparam int HALF_W = PROD_W + 1;
  localparam int SUM_W = PROD_W + 2;
  // Sum after dropping the 16 fraction bits of the weights
  localparam int FLOOR_W = SUM_W - 16;

  // One curve beat
  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] ctrl1_x;
    logic signed [COORD_W-1:0] ctrl1_y;
    logic signed [COORD_W-1:0] ctrl2_x;
    logic signed [COORD_W-1:0] ctrl2_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [7:0]                segment_count;
    logic [31:0]               line_color;
    logic [15:0]               line_width;
  } curve_t;

  // One segment beat
  typedef struct packed {
    logic signed [COORD_W-1:0] from_x;
    logic signed [COORD_W-1:0] from_y;
    logic signed [COORD_W-1:0] to_x;
    logic signed [COORD_W-1:0] to_y;
    logic [31:0]               seg_color;
    logic [15:0]               seg_width;
    logic                      last_segment;
  } segment_t;

  // Controller to datapath: one step per cycle at most
  typedef struct packed {
    logic load;      // capture curve, clear step and divider state
    logic div_step;  // one restoring step of 65536 / n
    logic t_step;    // advance t to the next segment
    logic mul_sq;    // u^2, t^2
    logic mul_cube;  // the four weights
    logic mul_pt;    // weights times coordinates
    logic sum_pair;  // pair sums
    logic emit;      // final sum, floor, saturate, present segment
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;      // current segment is the final one
  } dp_status_t;

endpackage

/* src/cubic_bezier_flattener_core.sv */
// ----------------------------------------------------------------------------
// cubic_bezier_flattener_core - cubic Bezier to line segments
// Uniform subdivision of one curve into 1..MAX_SEGMENTS straight segments.
// ----------------------------------------------------------------------------
// Usage:
//   Present a curve beat on curve and pulse start; it is taken at the rising
//   edge where start is high and busy is low. busy then stays high until the
//   cycle in which the final segment is shown.
//   Segments come out in order, each on segment for exactly one cycle with
//   segment_valid high; the receiver must take every beat as it comes.
//   last_segment marks the final one.
// Sequence:
//   A restoring divider first forms 65536/n. Each segment then passes
//   through six steps in the shared weight and product registers
//   (t step, squares, cubes, point products, pair sums, final sum).
//   A new curve may be started in the cycle the last segment is shown;
//   until then busy stays high and start is not taken.
// Reset:
//   rst (synchronous) returns the sequencer to idle and drops segment_valid;
//   a curve in flight is abandoned.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener_core #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bzf_pkg::curve_t   curve,
  output logic              segment_valid,
  output bzf_pkg::segment_t segment
);
  import bzf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  bzf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  bzf_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .curve         (curve),
    .cmd           (cmd),
    .status        (status),
    .segment_valid (segment_valid),
    .segment       (segment)
  );

  // A curve ends only with its final segment on the outputs
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> (segment_valid && segment.last_segment))
    else $error("curve ended without final segment");

  // Segments appear only out of a running curve
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    segment_valid |-> $past(busy))
    else $error("segment beat while idle");

endmodule

/* src/bzf_ctrl.sv */
// ----------------------------------------------------------------------------
// bzf_ctrl - sequencer for the Bezier flattener
// Runs the divider setup once per curve, then the six-step segment sequence
// until the datapath flags the final segment.
// ----------------------------------------------------------------------------
module bzf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  bzf_pkg::dp_status_t status,
  output bzf_pkg::dp_cmd_t    cmd
);
  import bzf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_TSTEP = 3'd2;
  localparam logic [2:0] S_SQ    = 3'd3;
  localparam logic [2:0] S_CUBE  = 3'd4;
  localparam logic [2:0] S_PT    = 3'd5;
  localparam logic [2:0] S_PAIR  = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  localparam int CNT_W = $clog2(Q_W);

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] div_cnt, div_cnt_next;

  assign busy = (state != S_IDLE);

  // Next state and step commands
  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          div_cnt_next = '0;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == CNT_W'(Q_W - 1)) begin
          state_next = S_TSTEP;
        end
      end
      S_TSTEP: begin
        cmd.t_step = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.mul_sq = 1'b1;
        state_next = S_CUBE;
      end
      S_CUBE: begin
        cmd.mul_cube = 1'b1;
        state_next   = S_PT;
      end
      S_PT: begin
        cmd.mul_pt = 1'b1;
        state_next = S_PAIR;
      end
      S_PAIR: begin
        cmd.sum_pair = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = status.last ? S_IDLE : S_TSTEP;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  // At most one datapath step per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath step issued");

  // Division runs exactly its step count before the first t step
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && state_next == S_TSTEP) |-> (div_cnt == CNT_W'(Q_W - 1)))
    else $error("divider left early");

endmodule

/* src/bzf_datapath.sv */
// ----------------------------------------------------------------------------
// bzf_datapath - arithmetic for the Bezier flattener
// Restoring divider for 65536/n, incremental t, Bernstein weights, weighted
// point sum with floor and saturation, and the segment output register.
// ----------------------------------------------------------------------------
module bzf_datapath #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  bzf_pkg::curve_t     curve,
  input  bzf_pkg::dp_cmd_t    cmd,
  output bzf_pkg::dp_status_t status,
  output logic                segment_valid,
  output bzf_pkg::segment_t   segment
);
  import bzf_pkg::*;

  localparam int NW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS + 1) : 1;

  // Captured curve and step state
  curve_t                     curve_q;
  logic [NW-1:0]              n, seg_idx;
  logic [Q_W-1:0]             dvd, quo;
  logic [NW:0]                rem, racc;
  logic [Q_W-1:0]             t;
  logic signed [COORD_W-1:0]  prev_x, prev_y;

  // Weight pipeline
  logic [Q_W-1:0]             u2, t2;
  logic [W_W-1:0]             w [4];
  logic signed [PROD_W-1:0]   prod_x [4];
  logic signed [PROD_W-1:0]   prod_y [4];
  logic signed [HALF_W-1:0]   pa_x, pb_x, pa_y, pb_y;

  // Combinational helpers
  logic [NW-1:0]              n_clamp;
  logic [NW:0]                rem_sh, racc_sum;
  logic                       div_geq, racc_wrap;
  logic [Q_W-1:0]             u;
  logic [2*Q_W-1:0]           uu, tt, u2u, u2t, ut2, t2t;
  logic [Q_W-1:0]             m1, m2;
  logic signed [SUM_W-1:0]    sum_x, sum_y;
  logic signed [COORD_W-1:0]  pt_x, pt_y;
  logic signed [W_W:0]        ws [4];

  // Saturate the floored sum to the coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [FLOOR_W-1:0] v);
    logic [FLOOR_W-COORD_W:0] top;
    top = v[FLOOR_W-1:COORD_W-1];
    if ((&top) || !(|top)) begin
      sat_coord = v[COORD_W-1:0];
    end else if (v[FLOOR_W-1]) begin
      sat_coord = COORD_MIN;
    end else begin
      sat_coord = COORD_MAX;
    end
  endfunction

  // Clamp the requested count to 1..MAX_SEGMENTS
  always_comb begin
    if (curve.segment_count == 8'd0) begin
      n_clamp = NW'(1);
    end else if (curve.segment_count > 8'(MAX_SEGMENTS)) begin
      n_clamp = NW'(MAX_SEGMENTS);
    end else begin
      n_clamp = NW'(curve.segment_count);
    end
  end

  // Divider step and t remainder
  assign rem_sh    = {rem[NW-1:0], dvd[Q_W-1]};
  assign div_geq   = (rem_sh >= {1'b0, n});
  assign racc_sum  = racc + rem;
  assign racc_wrap = (racc_sum >= {1'b0, n});

  // Weight products
  assign u   = ONE_Q16 - t;
  assign uu  = u * u;
  assign tt  = t * t;
  assign u2u = u2 * u;
  assign u2t = u2 * t;
  assign ut2 = u * t2;
  assign t2t = t2 * t;
  assign m1  = u2t[Q_W+15:16];
  assign m2  = ut2[Q_W+15:16];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ws[k] = $signed({1'b0, w[k]});
    end
  end

  // Final sum; the arithmetic shift by 16 is the floor
  assign sum_x = SUM_W'(pa_x) + SUM_W'(pb_x);
  assign sum_y = SUM_W'(pa_y) + SUM_W'(pb_y);
  assign pt_x  = sat_coord(sum_x[SUM_W-1:16]);
  assign pt_y  = sat_coord(sum_y[SUM_W-1:16]);

  assign status.last = (seg_idx == n);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_valid <= 1'b0;
    end else begin
      segment_valid <= cmd.emit;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      curve_q <= curve;
      n       <= n_clamp;
      seg_idx <= '0;
      dvd     <= ONE_Q16;
      quo     <= '0;
      rem     <= '0;
      racc    <= '0;
      t       <= '0;
      prev_x  <= curve.start_x;
      prev_y  <= curve.start_y;
    end
    if (cmd.div_step) begin
      dvd <= {dvd[Q_W-2:0], 1'b0};
      quo <= {quo[Q_W-2:0], div_geq};
      rem <= div_geq ? (rem_sh - {1'b0, n}) : rem_sh;
    end
    if (cmd.t_step) begin
      seg_idx <= seg_idx + 1'b1;
      racc    <= racc_wrap ? (racc_sum - {1'b0, n}) : racc_sum;
      t       <= t + quo + Q_W'(racc_wrap);
    end
    if (cmd.mul_sq) begin
      u2 <= uu[Q_W+15:16];
      t2 <= tt[Q_W+15:16];
    end
    if (cmd.mul_cube) begin
      w[0] <= W_W'(u2u[Q_W+15:16]);
      w[1] <= W_W'({m1, 1'b0}) + W_W'(m1);
      w[2] <= W_W'({m2, 1'b0}) + W_W'(m2);
      w[3] <= W_W'(t2t[Q_W+15:16]);
    end
    if (cmd.mul_pt) begin
      prod_x[0] <= ws[0] * curve_q.start_x;
      prod_x[1] <= ws[1] * curve_q.ctrl1_x;
      prod_x[2] <= ws[2] * curve_q.ctrl2_x;
      prod_x[3] <= ws[3] * curve_q.end_x;
      prod_y[0] <= ws[0] * curve_q.start_y;
      prod_y[1] <= ws[1] * curve_q.ctrl1_y;
      prod_y[2] <= ws[2] * curve_q.ctrl2_y;
      prod_y[3] <= ws[3] * curve_q.end_y;
    end
    if (cmd.sum_pair) begin
      pa_x <= HALF_W'(prod_x[0]) + HALF_W'(prod_x[1]);
      pb_x <= HALF_W'(prod_x[2]) + HALF_W'(prod_x[3]);
      pa_y <= HALF_W'(prod_y[0]) + HALF_W'(prod_y[1]);
      pb_y <= HALF_W'(prod_y[2]) + HALF_W'(prod_y[3]);
    end
    if (cmd.emit) begin
      segment.from_x       <= prev_x;
      segment.from_y       <= prev_y;
      segment.to_x         <= pt_x;
      segment.to_y         <= pt_y;
      segment.seg_color    <= curve_q.line_color;
      segment.seg_width    <= curve_q.line_width;
      segment.last_segment <= status.last;
      prev_x               <= pt_x;
      prev_y               <= pt_y;
    end
  end

  // The incremental t lands on exactly one at the final segment
  a_t_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.last) |-> (t == ONE_Q16))
    else $error("t not at one on final segment");

  // The final point is the curve end point
  a_end_pt: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.last) |-> (pt_x == curve_q.end_x && pt_y == curve_q.end_y))
    else $error("final point differs from end point");

endmodule
